FILE: src/ordered_list_engine_defines.svh
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// condition implies consequence in the same cycle
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ole_pkg.sv
package ole_pkg;

  // default sizes
  localparam int unsigned CapacityDef   = 64;
  localparam int unsigned HandleBitsDef = 16;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_MOVE   = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_READ   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_BADIDX = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_LOCKED = 3'd3,
    STAT_NONE   = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_FETCH = 3'd1,
    ST_SHIFT = 3'd2,
    ST_PLACE = 3'd3,
    ST_SCAN  = 3'd4
  } state_e;

endpackage

FILE: src/ole_mem.sv
module ole_mem #(
  parameter int unsigned Depth = ole_pkg::CapacityDef,
  parameter int unsigned Width = ole_pkg::HandleBitsDef + 1,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ordered_list_engine.sv
// last step before done_o: append, clear and beats refused on index or kind in idle, read,
// a remove refused for the lock and a move onto itself in fetch, find after a scan from
// the start index, remove after shifting the entries above it, move after a shift run and
// a place; shifts and scans move one entry per cycle on the single entry memory port pair
// throughput: one beat at a time, busy is low while done_o is high so the next beat follows
// reset clears the count and the sequencer; the entry memory is not cleared; no stalls
`include "ordered_list_engine_defines.svh"

module ordered_list_engine #(
  parameter int unsigned CAPACITY    = ole_pkg::CapacityDef,
  parameter int unsigned HANDLE_BITS = ole_pkg::HandleBitsDef,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned EntW = HANDLE_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             kind_i,
  input  logic [HANDLE_BITS-1:0] entry_handle_i,
  input  logic                   entry_playable_i,
  input  logic [IdxW-1:0]        index_first_i,
  input  logic [IdxW-1:0]        index_second_i,
  input  logic [HANDLE_BITS-1:0] locked_handle_i,
  input  logic                   lock_active_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [CntW-1:0]        list_length_o,
  output logic [IdxW-1:0]        result_index_o,
  output logic [HANDLE_BITS-1:0] result_handle_o,
  output logic                   result_playable_o,
  output logic                   removed_was_loaded_o
);

  ole_pkg::state_e state_q, state_d;
  ole_pkg::kind_e  kind_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        ptr_q, ptr_d;
  logic                   down_q, down_d;
  logic [IdxW-1:0]        ia_q, ib_q;
  logic [HANDLE_BITS-1:0] lockh_q;
  logic                   lockon_q;
  logic [EntW-1:0]        moving_q, moving_d;
  logic                   accept;

  // memory port signals
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic            rd_play;

  // result of the finishing step
  logic                   fin;
  ole_pkg::status_e       fin_status;
  logic [IdxW-1:0]        fin_idx;
  logic [HANDLE_BITS-1:0] fin_handle;
  logic                   fin_play, fin_loaded;

  logic                   res_valid_q;
  ole_pkg::status_e       res_status_q;
  logic [CntW-1:0]        res_len_q;
  logic [IdxW-1:0]        res_idx_q;
  logic [HANDLE_BITS-1:0] res_handle_q;
  logic                   res_play_q, res_loaded_q;

  logic shift_last;

  assign busy      = (state_q != ole_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
  assign rd_play   = mem_rdata[HANDLE_BITS];

  // entry memory
  ole_mem #(
    .Depth(CAPACITY),
    .Width(EntW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // last write of a shift run
  always_comb begin
    if (kind_q == ole_pkg::KIND_REMOVE) begin
      shift_last = ((CntW'(ptr_q) + CntW'(2)) == cnt_q);
    end else if (down_q) begin
      shift_last = (ptr_q == IdxW'(ib_q + IdxW'(1)));
    end else begin
      shift_last = (IdxW'(ptr_q + IdxW'(1)) == ib_q);
    end
  end

  // sequencer next state and memory control
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    down_d     = down_q;
    moving_d   = moving_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    fin        = 1'b0;
    fin_status = ole_pkg::STAT_OK;
    fin_idx    = '0;
    fin_handle = '0;
    fin_play   = 1'b0;
    fin_loaded = 1'b0;
    case (state_q)
      ole_pkg::ST_IDLE: begin
        if (start) begin
          case (ole_pkg::kind_e'(kind_i))
            ole_pkg::KIND_APPEND: begin
              fin = 1'b1;
              if (cnt_q == CntW'(CAPACITY)) begin
                fin_status = ole_pkg::STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = IdxW'(cnt_q);
                mem_wdata  = {entry_playable_i, entry_handle_i};
                cnt_d      = cnt_q + CntW'(1);
                fin_idx    = IdxW'(cnt_q);
                fin_handle = entry_handle_i;
                fin_play   = entry_playable_i;
              end
            end
            ole_pkg::KIND_REMOVE, ole_pkg::KIND_READ: begin
              if (CntW'(index_first_i) >= cnt_q) begin
                fin        = 1'b1;
                fin_status = ole_pkg::STAT_BADIDX;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = index_first_i;
                state_d   = ole_pkg::ST_FETCH;
              end
            end
            ole_pkg::KIND_MOVE: begin
              if ((CntW'(index_first_i) >= cnt_q) || (CntW'(index_second_i) >= cnt_q)) begin
                fin        = 1'b1;
                fin_status = ole_pkg::STAT_BADIDX;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = index_first_i;
                state_d   = ole_pkg::ST_FETCH;
              end
            end
            ole_pkg::KIND_FIND: begin
              if (CntW'(index_first_i) >= cnt_q) begin
                fin        = 1'b1;
                fin_status = ole_pkg::STAT_NONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = index_first_i;
                ptr_d     = index_first_i;
                state_d   = ole_pkg::ST_SCAN;
              end
            end
            ole_pkg::KIND_CLEAR: begin
              fin = 1'b1;
              if (lock_active_i) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {1'b1, locked_handle_i};
                cnt_d      = CntW'(1);
                fin_handle = locked_handle_i;
                fin_play   = 1'b1;
              end else begin
                cnt_d = '0;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ole_pkg::STAT_BADIDX;
            end
          endcase
        end
      end
      ole_pkg::ST_FETCH: begin
        case (kind_q)
          ole_pkg::KIND_READ: begin
            fin        = 1'b1;
            fin_idx    = ia_q;
            fin_handle = rd_handle;
            fin_play   = rd_play;
            state_d    = ole_pkg::ST_IDLE;
          end
          ole_pkg::KIND_REMOVE: begin
            moving_d = mem_rdata;
            if ((rd_handle == lockh_q) && lockon_q) begin
              fin        = 1'b1;
              fin_status = ole_pkg::STAT_LOCKED;
              fin_handle = rd_handle;
              state_d    = ole_pkg::ST_IDLE;
            end else if ((CntW'(ia_q) + CntW'(1)) == cnt_q) begin
              cnt_d      = cnt_q - CntW'(1);
              fin        = 1'b1;
              fin_handle = rd_handle;
              fin_loaded = (rd_handle == lockh_q);
              state_d    = ole_pkg::ST_IDLE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = IdxW'(ia_q + IdxW'(1));
              ptr_d     = ia_q;
              down_d    = 1'b0;
              state_d   = ole_pkg::ST_SHIFT;
            end
          end
          ole_pkg::KIND_MOVE: begin
            moving_d = mem_rdata;
            if (ia_q == ib_q) begin
              fin     = 1'b1;
              state_d = ole_pkg::ST_IDLE;
            end else begin
              mem_re  = 1'b1;
              ptr_d   = ia_q;
              down_d  = (ia_q > ib_q);
              state_d = ole_pkg::ST_SHIFT;
              if (ia_q > ib_q) begin
                mem_raddr = IdxW'(ia_q - IdxW'(1));
              end else begin
                mem_raddr = IdxW'(ia_q + IdxW'(1));
              end
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = ole_pkg::STAT_BADIDX;
            state_d    = ole_pkg::ST_IDLE;
          end
        endcase
      end
      ole_pkg::ST_SHIFT: begin
        // write the neighbor read last cycle, read the next one ahead
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = mem_rdata;
        if (shift_last) begin
          if (kind_q == ole_pkg::KIND_REMOVE) begin
            cnt_d      = cnt_q - CntW'(1);
            fin        = 1'b1;
            fin_handle = moving_q[HANDLE_BITS-1:0];
            fin_loaded = (moving_q[HANDLE_BITS-1:0] == lockh_q);
            state_d    = ole_pkg::ST_IDLE;
          end else begin
            state_d = ole_pkg::ST_PLACE;
          end
        end else begin
          mem_re = 1'b1;
          if (down_q) begin
            mem_raddr = IdxW'(ptr_q - IdxW'(2));
            ptr_d     = IdxW'(ptr_q - IdxW'(1));
          end else begin
            mem_raddr = IdxW'(ptr_q + IdxW'(2));
            ptr_d     = IdxW'(ptr_q + IdxW'(1));
          end
        end
      end
      ole_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = ib_q;
        mem_wdata = moving_q;
        fin       = 1'b1;
        state_d   = ole_pkg::ST_IDLE;
      end
      ole_pkg::ST_SCAN: begin
        // one entry checked per cycle, next read already issued
        if (rd_play) begin
          fin        = 1'b1;
          fin_idx    = ptr_q;
          fin_handle = rd_handle;
          fin_play   = 1'b1;
          state_d    = ole_pkg::ST_IDLE;
        end else if ((CntW'(ptr_q) + CntW'(1)) == cnt_q) begin
          fin        = 1'b1;
          fin_status = ole_pkg::STAT_NONE;
          state_d    = ole_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IdxW'(ptr_q + IdxW'(1));
          ptr_d     = IdxW'(ptr_q + IdxW'(1));
        end
      end
      default: begin
        state_d = ole_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ole_pkg::ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= fin;
    end
  end

  // captured beat and work registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= ole_pkg::kind_e'(kind_i);
      ia_q     <= index_first_i;
      ib_q     <= index_second_i;
      lockh_q  <= locked_handle_i;
      lockon_q <= lock_active_i;
    end
    ptr_q    <= ptr_d;
    down_q   <= down_d;
    moving_q <= moving_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_status_q <= fin_status;
      res_len_q    <= cnt_d;
      res_idx_q    <= fin_idx;
      res_handle_q <= fin_handle;
      res_play_q   <= fin_play;
      res_loaded_q <= fin_loaded;
    end
  end

  assign done_o               = res_valid_q;
  assign status_o             = res_status_q;
  assign list_length_o        = res_len_q;
  assign result_index_o       = res_idx_q;
  assign result_handle_o      = res_handle_q;
  assign result_playable_o    = res_play_q;
  assign removed_was_loaded_o = res_loaded_q;

  // checks
  `OLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(CAPACITY), "entry count above capacity")
  `OLE_ASSERT_NOW(a_done_cause, done_o, $past(accept) || $past(busy), "result beat without work")
  `OLE_ASSERT_NOW(a_shift_ports, (state_q == ole_pkg::ST_SHIFT) && mem_re,
                  mem_raddr != mem_waddr, "shift reads the entry it writes")
  `OLE_ASSERT_NEXT(a_append_grow,
                   accept && (kind_i == ole_pkg::KIND_APPEND) && (cnt_q != CntW'(CAPACITY)),
                   cnt_q == CntW'($past(cnt_q) + CntW'(1)), "append did not grow the list")

endmodule
